[rtl/lorentz_motion_derivative_unit_defines.svh]
// ----------------------------------------------------------------------------
// Lorentz motion derivative unit: assertion macros
// Shared concurrent-assertion shorthands, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LORENTZ_MOTION_DERIVATIVE_UNIT_DEFINES_SVH
`define LORENTZ_MOTION_DERIVATIVE_UNIT_DEFINES_SVH

// same-cycle implication
`define LMD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LMD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/lmd_pkg.sv]
// ----------------------------------------------------------------------------
// Lorentz motion derivative package
// Types, constants and helpers shared by the datapath modules.
// ----------------------------------------------------------------------------
package lmd_pkg;

	localparam int WORD_W     = 32;
	localparam int SUM_W      = 64;
	localparam int ROOT_STEPS = SUM_W / 2;
	localparam int QUOT_W     = 32;
	localparam int NUM_W      = 80;
	localparam int POS_NUM_W  = 48;
	localparam int LANES      = 6;
	localparam int CFG_IDX_W  = 2;

	localparam logic [WORD_W-1:0] COEF_RESET = 32'h0001_0000;
	localparam logic [WORD_W-1:0] SAT_NEG    = 32'h8000_0000;
	localparam logic [WORD_W-1:0] SAT_POS    = 32'h7FFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EQUATION_MODE = 2'd0,
		CFG_REVERSE_TIME  = 2'd1,
		CFG_FORCE_COEF    = 2'd2
	} cfg_idx_t;

	// configuration as seen by the datapath
	typedef struct packed {
		logic              mode;
		logic              rev;
		logic [WORD_W-1:0] coef;
	} cfg_t;

	// one input word
	typedef struct packed {
		logic [WORD_W-1:0] momentum_x;
		logic [WORD_W-1:0] momentum_y;
		logic [WORD_W-1:0] momentum_z;
		logic [WORD_W-1:0] field_x;
		logic [WORD_W-1:0] field_y;
		logic [WORD_W-1:0] field_z;
	} vec_in_t;

	// carried alongside the square root
	typedef struct packed {
		logic                           mode;
		logic [2:0]                     neg_pos;
		logic [2:0]                     neg_mom;
		logic [2:0][POS_NUM_W-1:0]      num_pos;
		logic [2:0][NUM_W-1:0]          num_mom;
	} side_t;

	// carried alongside the divider lanes
	typedef struct packed {
		logic             mode;
		logic             zero;
		logic [LANES-1:0] neg;
	} tag_t;

	typedef struct packed {
		tag_t                         tag;
		logic [LANES-1:0][QUOT_W-1:0] quot;
		logic [LANES-1:0]             ovf;
	} div_res_t;

	function automatic logic [WORD_W-1:0] abs32(logic [WORD_W-1:0] v);
		return v[WORD_W-1] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic [63:0] mul_u32(logic [31:0] a, logic [31:0] b);
		logic [63:0] r;
		r = {32'b0, a} * {32'b0, b};
		return r;
	endfunction

	function automatic logic [63:0] mul_s32(logic [31:0] a, logic [31:0] b);
		logic signed [63:0] r;
		r = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
		return r;
	endfunction

	// sign and saturate a quotient magnitude
	function automatic logic [WORD_W-1:0] sat_q(logic [QUOT_W-1:0] q, logic ovf, logic neg);
		logic [WORD_W-1:0] r;
		if (neg) begin
			r = (ovf || q[QUOT_W-1]) ? SAT_NEG : (~q + 32'd1);
		end else begin
			r = (ovf || q[QUOT_W-1]) ? SAT_POS : q;
		end
		return r;
	endfunction

endpackage

[rtl/lmd_if.sv]
// ----------------------------------------------------------------------------
// Lorentz motion derivative channels
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface lmd_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] momentum_x;
	logic [31:0] momentum_y;
	logic [31:0] momentum_z;
	logic [31:0] field_x;
	logic [31:0] field_y;
	logic [31:0] field_z;

	modport source (output valid, momentum_x, momentum_y, momentum_z,
		field_x, field_y, field_z, input ready);
	modport sink (input valid, momentum_x, momentum_y, momentum_z,
		field_x, field_y, field_z, output ready);
endinterface

interface lmd_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] deriv_pos_x;
	logic [31:0] deriv_pos_y;
	logic [31:0] deriv_pos_z;
	logic [31:0] deriv_mom_x;
	logic [31:0] deriv_mom_y;
	logic [31:0] deriv_mom_z;
	logic        zero_magnitude;

	modport source (output valid, deriv_pos_x, deriv_pos_y, deriv_pos_z,
		deriv_mom_x, deriv_mom_y, deriv_mom_z, zero_magnitude, input ready);
	modport sink (input valid, deriv_pos_x, deriv_pos_y, deriv_pos_z,
		deriv_mom_x, deriv_mom_y, deriv_mom_z, zero_magnitude, output ready);
endinterface

interface lmd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/lmd_front.sv]
// ----------------------------------------------------------------------------
// Lorentz motion derivative front end
// Four stages: squares and cross terms, sums, force partial products, and
// the force numerator. Feeds the square root with the sum of squares.
// ----------------------------------------------------------------------------
module lmd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  lmd_pkg::vec_in_t    in_word,
	input  lmd_pkg::cfg_t       cfg,
	output logic                out_valid,
	output logic [63:0]         out_sum,
	output lmd_pkg::side_t      out_side
);

	logic [2:0][31:0] p, b, n;

	// stage 1 registers
	logic             vld_s1, mode_s1, rev_s1, cneg_s1;
	logic [31:0]      fa_s1;
	logic [2:0][31:0] nabs_s1;
	logic [2:0]       nneg_s1;
	logic [2:0][63:0] sq_s1;
	logic [5:0][63:0] xt_s1;

	// stage 2 registers
	logic             vld_s2, mode_s2;
	logic [31:0]      fa_s2;
	logic [63:0]      sum_s2;
	logic [2:0][63:0] cabs_s2;
	logic [2:0]       npos_s2, nmom_s2;
	logic [2:0][31:0] nabs_s2;

	// stage 3 registers
	logic             vld_s3, mode_s3;
	logic [63:0]      sum_s3;
	logic [2:0][63:0] plo_s3, phi_s3;
	logic [2:0]       npos_s3, nmom_s3;
	logic [2:0][31:0] nabs_s3;

	// stage 4 registers
	logic             vld_s4, mode_s4;
	logic [63:0]      sum_s4;
	logic [2:0][79:0] num_s4;
	logic [2:0]       npos_s4, nmom_s4;
	logic [2:0][31:0] nabs_s4;

	// stage 1: pick the normalizing vector
	always_comb begin
		p = {in_word.momentum_z, in_word.momentum_y, in_word.momentum_x};
		b = {in_word.field_z, in_word.field_y, in_word.field_x};
		n = cfg.mode ? b : p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1: squares and cross terms
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= cfg.mode;
			rev_s1  <= cfg.rev;
			cneg_s1 <= cfg.coef[31];
			fa_s1   <= lmd_pkg::abs32(cfg.coef);
			for (int i = 0; i < 3; i++) begin
				nabs_s1[i] <= lmd_pkg::abs32(n[i]);
				nneg_s1[i] <= n[i][31];
				sq_s1[i]   <= lmd_pkg::mul_u32(lmd_pkg::abs32(n[i]), lmd_pkg::abs32(n[i]));
			end
			xt_s1[0] <= lmd_pkg::mul_s32(p[1], b[2]);
			xt_s1[1] <= lmd_pkg::mul_s32(p[2], b[1]);
			xt_s1[2] <= lmd_pkg::mul_s32(p[2], b[0]);
			xt_s1[3] <= lmd_pkg::mul_s32(p[0], b[2]);
			xt_s1[4] <= lmd_pkg::mul_s32(p[0], b[1]);
			xt_s1[5] <= lmd_pkg::mul_s32(p[1], b[0]);
		end
	end

	// stage 2: sum of squares, cross product magnitudes and signs
	logic [2:0][64:0] cdiff, cneg_v;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cdiff[i]  = {xt_s1[2*i][63], xt_s1[2*i]} - {xt_s1[2*i+1][63], xt_s1[2*i+1]};
			cneg_v[i] = ~cdiff[i] + 65'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
			fa_s2   <= fa_s1;
			sum_s2  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			nabs_s2 <= nabs_s1;
			for (int i = 0; i < 3; i++) begin
				cabs_s2[i] <= cdiff[i][64] ? cneg_v[i][63:0] : cdiff[i][63:0];
				npos_s2[i] <= nneg_s1[i] ^ rev_s1;
				nmom_s2[i] <= cneg_s1 ^ cdiff[i][64] ^ rev_s1;
			end
		end
	end

	// stage 3: coefficient times cross product, two halves
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3 <= mode_s2;
			sum_s3  <= sum_s2;
			npos_s3 <= npos_s2;
			nmom_s3 <= nmom_s2;
			nabs_s3 <= nabs_s2;
			for (int i = 0; i < 3; i++) begin
				plo_s3[i] <= lmd_pkg::mul_u32(fa_s2, cabs_s2[i][31:0]);
				phi_s3[i] <= lmd_pkg::mul_u32(fa_s2, cabs_s2[i][63:32]);
			end
		end
	end

	// stage 4: join halves, drop the 2^16 of the divisor
	logic [2:0][95:0] prod;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = {32'b0, plo_s3[i]} + {phi_s3[i], 32'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s4 <= mode_s3;
			sum_s4  <= sum_s3;
			npos_s4 <= npos_s3;
			nmom_s4 <= nmom_s3;
			nabs_s4 <= nabs_s3;
			for (int i = 0; i < 3; i++) begin
				num_s4[i] <= prod[i][95:16];
			end
		end
	end

	always_comb begin
		out_valid        = vld_s4;
		out_sum          = sum_s4;
		out_side.mode    = mode_s4;
		out_side.neg_pos = npos_s4;
		out_side.neg_mom = nmom_s4;
		out_side.num_mom = num_s4;
		for (int i = 0; i < 3; i++) begin
			out_side.num_pos[i] = {nabs_s4[i], 16'b0};
		end
	end

endmodule

[rtl/lmd_isqrt.sv]
// ----------------------------------------------------------------------------
// Lorentz motion derivative square root
// Integer square root of a 64-bit sum, one result bit per stage.
// ----------------------------------------------------------------------------
module lmd_isqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [63:0]         in_sum,
	input  lmd_pkg::side_t      in_side,
	output logic                out_valid,
	output logic [31:0]         out_root,
	output lmd_pkg::side_t      out_side
);

	localparam int N = lmd_pkg::ROOT_STEPS;

	logic           vld_s  [N+1];
	logic [63:0]    rad_s  [N+1];
	logic [63:0]    root_s [N+1];
	lmd_pkg::side_t side_s [N+1];

	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = in_sum;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;
		logic        take;

		// trial subtract of the current root bit
		always_comb begin
			trial = root_s[k] + BIT;
			take  = rad_s[k] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= take ? (rad_s[k] - trial) : rad_s[k];
				root_s[k+1] <= take ? ((root_s[k] >> 1) + BIT) : (root_s[k] >> 1);
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_root  = root_s[N][31:0];
	assign out_side  = side_s[N];

endmodule

[rtl/lmd_divide.sv]
// ----------------------------------------------------------------------------
// Lorentz motion derivative divider
// Six restoring division lanes by the magnitude: an overflow check stage,
// then one quotient bit per stage.
// ----------------------------------------------------------------------------
module lmd_divide (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [31:0]         in_root,
	input  lmd_pkg::side_t      in_side,
	output logic                out_valid,
	output lmd_pkg::div_res_t   out_res
);

	localparam int N = lmd_pkg::QUOT_W;
	localparam int L = lmd_pkg::LANES;

	logic [L-1:0][79:0] num;

	logic                vld_s [N+1];
	logic [31:0]         div_s [N+1];
	logic [L-1:0][31:0]  rem_s [N+1];
	logic [L-1:0][31:0]  quo_s [N+1];
	logic [L-1:0]        ovf_s [N+1];
	lmd_pkg::tag_t       tag_s [N+1];

	// lane numerators: directions then forces
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i]   = {32'b0, in_side.num_pos[i]};
			num[i+3] = in_side.num_mom[i];
		end
	end

	// entry stage: overflow check, split numerator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0]      <= in_root;
			tag_s[0].mode <= in_side.mode;
			tag_s[0].zero <= (in_root == 32'd0);
			tag_s[0].neg  <= {in_side.neg_mom, in_side.neg_pos};
			for (int i = 0; i < L; i++) begin
				ovf_s[0][i] <= num[i][79:32] >= {16'b0, in_root};
				rem_s[0][i] <= num[i][63:32];
				quo_s[0][i] <= num[i][31:0];
			end
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [L-1:0][32:0] shifted;
		logic [L-1:0]       take;

		// shift in the next numerator bit and trial subtract
		always_comb begin
			for (int i = 0; i < L; i++) begin
				shifted[i] = {rem_s[k][i], quo_s[k][i][31]};
				take[i]    = shifted[i] >= {1'b0, div_s[k]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1] <= div_s[k];
				ovf_s[k+1] <= ovf_s[k];
				tag_s[k+1] <= tag_s[k];
				for (int i = 0; i < L; i++) begin
					rem_s[k+1][i] <= take[i] ? 32'(shifted[i] - {1'b0, div_s[k]})
						: shifted[i][31:0];
					quo_s[k+1][i] <= {quo_s[k][i][30:0], take[i]};
				end
			end
		end
	end

	assign out_valid    = vld_s[N];
	assign out_res.tag  = tag_s[N];
	assign out_res.quot = quo_s[N];
	assign out_res.ovf  = ovf_s[N];

endmodule

[rtl/lorentz_motion_derivative_unit.sv]
// Stages from an accepted input word to its result word: 4 front stages,
// 32 square root stages, 33 divider stages and 1 output stage.
// Throughput: one word per cycle; the whole pipeline holds only while the
// output register is full and not taken.
// Reset: asynchronous, clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// Lorentz motion derivative unit
// Unit direction and magnetic force term of a momentum/field pair, Q16.16.
// ----------------------------------------------------------------------------
`include "lorentz_motion_derivative_unit_defines.svh"

module lorentz_motion_derivative_unit (
	input  logic  clk,
	input  logic  arst_n,
	lmd_in_if.sink    data_in,
	lmd_out_if.source data_out,
	lmd_cfg_if.sink   cfg
);

	logic                 en;
	lmd_pkg::cfg_t        cfg_q;
	lmd_pkg::vec_in_t     in_word;

	logic                 fr_valid;
	logic [63:0]          fr_sum;
	lmd_pkg::side_t       fr_side;

	logic                 sq_valid;
	logic [31:0]          sq_root;
	lmd_pkg::side_t       sq_side;

	logic                 dv_valid;
	lmd_pkg::div_res_t    dv_res;

	logic                 out_vld_q;
	logic [5:0][31:0]     word_q;
	logic                 zero_q;
	logic [5:0][31:0]     word_d;

	// pipeline advances unless the output word is held
	assign en            = !out_vld_q || data_out.ready;
	assign data_in.ready = en;
	assign cfg.ready     = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= 1'b0;
			cfg_q.rev  <= 1'b0;
			cfg_q.coef <= lmd_pkg::COEF_RESET;
		end else if (cfg.valid) begin
			unique case (lmd_pkg::cfg_idx_t'(cfg.index))
				lmd_pkg::CFG_EQUATION_MODE: cfg_q.mode <= cfg.data[0];
				lmd_pkg::CFG_REVERSE_TIME:  cfg_q.rev  <= cfg.data[0];
				lmd_pkg::CFG_FORCE_COEF:    cfg_q.coef <= cfg.data;
				default: ;
			endcase
		end
	end

	assign in_word.momentum_x = data_in.momentum_x;
	assign in_word.momentum_y = data_in.momentum_y;
	assign in_word.momentum_z = data_in.momentum_z;
	assign in_word.field_x    = data_in.field_x;
	assign in_word.field_y    = data_in.field_y;
	assign in_word.field_z    = data_in.field_z;

	lmd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (data_in.valid),
		.in_word   (in_word),
		.cfg       (cfg_q),
		.out_valid (fr_valid),
		.out_sum   (fr_sum),
		.out_side  (fr_side)
	);

	lmd_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.in_sum    (fr_sum),
		.in_side   (fr_side),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	lmd_divide u_divide (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_root   (sq_root),
		.in_side   (sq_side),
		.out_valid (dv_valid),
		.out_res   (dv_res)
	);

	// sign, saturate and mask the quotients
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			if (dv_res.tag.zero || (i >= 3 && dv_res.tag.mode)) begin
				word_d[i] = '0;
			end else begin
				word_d[i] = lmd_pkg::sat_q(dv_res.quot[i], dv_res.ovf[i], dv_res.tag.neg[i]);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= word_d;
			zero_q <= dv_res.tag.zero;
		end
	end

	assign data_out.valid          = out_vld_q;
	assign data_out.deriv_pos_x    = word_q[0];
	assign data_out.deriv_pos_y    = word_q[1];
	assign data_out.deriv_pos_z    = word_q[2];
	assign data_out.deriv_mom_x    = word_q[3];
	assign data_out.deriv_mom_y    = word_q[4];
	assign data_out.deriv_mom_z    = word_q[5];
	assign data_out.zero_magnitude = zero_q;

	// checks
	`LMD_ASSERT_SAME(a_zero_clears, data_out.valid && data_out.zero_magnitude, (word_q[0] == 32'd0) && (word_q[3] == 32'd0) && (word_q[5] == 32'd0), "zero magnitude with nonzero output")
	`LMD_ASSERT_SAME(a_field_line_no_force, data_out.valid && cfg_q.mode, (word_q[3] == 32'd0) && (word_q[4] == 32'd0) && (word_q[5] == 32'd0), "force term in field-line mode")
	`LMD_ASSERT_SAME(a_unit_bound, data_out.valid, ($signed(word_q[0]) <= 32'sd65536) && ($signed(word_q[0]) >= -32'sd65536), "direction beyond unit")
	`LMD_ASSERT_NEXT(a_mode_write, cfg.valid && (cfg.index == lmd_pkg::CFG_EQUATION_MODE), cfg_q.mode == $past(cfg.data[0]), "mode write lost")

endmodule

[tb/tb_lorentz_motion_derivative_unit.sv]
// ----------------------------------------------------------------------------
// Lorentz motion derivative unit testbench
// Drives momentum/field words through the unit under several register
// settings, predicts each result word with an integer model of the unit
// and checks every result word in order, mostly under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_lorentz_motion_derivative_unit;

	localparam logic [lmd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
	localparam int PERIOD = 8;

	typedef struct packed {
		logic [2:0][31:0] pos;
		logic [2:0][31:0] mom;
		logic             zero;
	} deriv_t;

	logic clk;
	logic arst_n;

	lmd_in_if  data_in ();
	lmd_out_if data_out ();
	lmd_cfg_if cfg ();

	lorentz_motion_derivative_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.data_in (data_in.sink),
		.data_out(data_out.source),
		.cfg     (cfg.sink)
	);

	// register copy used for prediction
	logic               mode_q;
	logic               rev_q;
	logic signed [31:0] coef_q;

	deriv_t expected_q[$];
	int     mismatches;
	bit     idle_en;
	int     hold_seq;
	int     hold_seen;
	int     hold_left;
	int     stall_left;

	// clock
	initial clk = 1'b0;
	always #(PERIOD / 2) clk = ~clk;

	// integer square root, floor
	function automatic logic [63:0] floor_sqrt(logic [63:0] n);
		logic [63:0] res;
		logic [63:0] b;
		res = 64'd0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// sign a magnitude and clamp to 32 bits
	function automatic logic [31:0] clamp_signed(logic [127:0] q, logic neg);
		if (neg) begin
			if (q >= 128'h8000_0000) return lmd_pkg::SAT_NEG;
			return 32'd0 - q[31:0];
		end
		if (q > 128'h7FFF_FFFF) return lmd_pkg::SAT_POS;
		return q[31:0];
	endfunction

	// expected derivative word for one momentum/field word
	function automatic deriv_t predict_derivative(lmd_pkg::vec_in_t w);
		deriv_t            r;
		longint            p[3];
		longint            b[3];
		longint            v[3];
		longint            c[3];
		logic [63:0]       a;
		logic [63:0]       sum;
		logic [63:0]       m;
		logic [127:0]      q;
		logic [127:0]      fa;
		logic [127:0]      ca;
		logic              neg;
		p[0] = $signed(w.momentum_x);
		p[1] = $signed(w.momentum_y);
		p[2] = $signed(w.momentum_z);
		b[0] = $signed(w.field_x);
		b[1] = $signed(w.field_y);
		b[2] = $signed(w.field_z);
		r = '0;
		sum = 64'd0;
		for (int i = 0; i < 3; i++) begin
			v[i] = mode_q ? b[i] : p[i];
			a = (v[i] < 0) ? -v[i] : v[i];
			sum = sum + a * a;
		end
		if (sum == 0) begin
			r.zero = 1'b1;
			return r;
		end
		m = floor_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			a = (v[i] < 0) ? -v[i] : v[i];
			q = {64'd0, (a << 16) / m};
			r.pos[2 - i] = clamp_signed(q, (v[i] < 0) != rev_q);
		end
		if (!mode_q) begin
			c[0] = p[1] * b[2] - p[2] * b[1];
			c[1] = p[2] * b[0] - p[0] * b[2];
			c[2] = p[0] * b[1] - p[1] * b[0];
			fa = (coef_q < 0) ? -longint'(coef_q) : longint'(coef_q);
			for (int i = 0; i < 3; i++) begin
				ca = (c[i] < 0) ? -c[i] : c[i];
				q = (fa * ca) / ({64'd0, m} << 16);
				neg = ((coef_q < 0) != (c[i] < 0)) != rev_q;
				r.mom[2 - i] = (q == 0) ? 32'd0 : clamp_signed(q, neg);
			end
		end
		return r;
	endfunction

	// send one word; valid stays high for a following word
	task automatic send_vector(logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
			logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
		lmd_pkg::vec_in_t w;
		if (idle_en && $urandom_range(0, 5) == 0) begin
			data_in.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		w = {mx, my, mz, bx, by, bz};
		data_in.valid      <= 1'b1;
		data_in.momentum_x <= mx;
		data_in.momentum_y <= my;
		data_in.momentum_z <= mz;
		data_in.field_x    <= bx;
		data_in.field_y    <= by;
		data_in.field_z    <= bz;
		@(posedge clk);
		while (!data_in.ready) @(posedge clk);
		expected_q.push_back(predict_derivative(w));
	endtask

	// drop valid and wait for every result word
	task automatic drain;
		data_in.valid <= 1'b0;
		wait (expected_q.size() == 0);
		@(posedge clk);
	endtask

	// register write, only with the unit idle
	task automatic write_reg(logic [lmd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
		drain();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			lmd_pkg::CFG_EQUATION_MODE: mode_q = value[0];
			lmd_pkg::CFG_REVERSE_TIME:  rev_q  = value[0];
			lmd_pkg::CFG_FORCE_COEF:    coef_q = value;
			default: ;
		endcase
	endtask

	function automatic logic [31:0] pick_component();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'd0;
			3: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20) :
				-$urandom_range(0, 1 << 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_coef();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'd0;
			3: return lmd_pkg::COEF_RESET;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random(int count);
		repeat (count) begin
			logic [31:0] c[6];
			foreach (c[i]) c[i] = pick_component();
			// now and then a zero normalizing vector
			if ($urandom_range(0, 19) == 0) begin
				if (mode_q) begin
					c[3] = 0; c[4] = 0; c[5] = 0;
				end else begin
					c[0] = 0; c[1] = 0; c[2] = 0;
				end
			end
			send_vector(c[0], c[1], c[2], c[3], c[4], c[5]);
		end
	endtask

	// extremes, zero vectors, overflow and both modes under reset settings and more
	task automatic test_directed;
		send_vector(0, 0, 0, 32'h0001_0000, 0, 0);
		send_vector(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0);
		send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vector(1, 0, 0, 0, 32'h7FFF_FFFF, 0);
		send_vector(32'hFFFF_FFFF, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1);
		send_vector(1, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		write_reg(lmd_pkg::CFG_FORCE_COEF, 32'h7FFF_FFFF);
		send_vector(1, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_vector(32'h8000_0000, 0, 1, 0, 32'h7FFF_FFFF, 32'h8000_0000);
		write_reg(lmd_pkg::CFG_FORCE_COEF, 32'h8000_0000);
		send_vector(1, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_vector(0, 0, 0, 0, 0, 0);
		write_reg(lmd_pkg::CFG_FORCE_COEF, 32'd0);
		send_vector(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 32'h0001_0000);
		write_reg(lmd_pkg::CFG_REVERSE_TIME, 32'd1);
		write_reg(lmd_pkg::CFG_FORCE_COEF, lmd_pkg::COEF_RESET);
		send_vector(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 32'h0001_0000);
		send_vector(0, 0, 0, 1, 2, 3);
		write_reg(lmd_pkg::CFG_EQUATION_MODE, 32'd1);
		send_vector(1, 2, 3, 0, 0, 0);
		send_vector(1, 2, 3, 32'h8000_0000, 0, 0);
		write_reg(lmd_pkg::CFG_REVERSE_TIME, 32'd0);
		send_vector(1, 2, 3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send_vector(0, 0, 0, 0, 32'hFFFF_FFFF, 0);
		// write to the unused index changes nothing
		write_reg(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
		send_vector(1, 2, 3, 4, 5, 6);
		write_reg(lmd_pkg::CFG_EQUATION_MODE, 32'd0);
		send_vector(1, 2, 3, 4, 5, 6);
		drain();
	endtask

	// random words under a run of register settings
	task automatic test_random_settings;
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(lmd_pkg::CFG_EQUATION_MODE, (ph % 4 == 3) ? 32'd1 : 32'd0);
			write_reg(lmd_pkg::CFG_REVERSE_TIME, $urandom_range(0, 1));
			write_reg(lmd_pkg::CFG_FORCE_COEF, pick_coef());
			send_random(140);
		end
		drain();
	endtask

	// receiver holds off long while words keep coming
	task automatic test_backpressure;
		write_reg(lmd_pkg::CFG_EQUATION_MODE, 32'd0);
		write_reg(lmd_pkg::CFG_FORCE_COEF, 32'h0002_8000);
		hold_seq++;
		send_random(150);
		drain();
	endtask

	// closing stretch with no idling at all
	task automatic test_full_rate;
		idle_en = 1'b0;
		write_reg(lmd_pkg::CFG_REVERSE_TIME, 32'd1);
		write_reg(lmd_pkg::CFG_FORCE_COEF, $urandom);
		send_random(130);
		write_reg(lmd_pkg::CFG_EQUATION_MODE, 32'd1);
		send_random(130);
		drain();
	endtask

	// result receiver: random stalls plus requested long hold
	always @(posedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen = hold_seq;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			data_out.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			data_out.ready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 17) - 1;
			data_out.ready <= 1'b0;
		end else begin
			data_out.ready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		deriv_t got;
		deriv_t want;
		if (arst_n && data_out.valid && data_out.ready) begin
			got.pos  = {data_out.deriv_pos_x, data_out.deriv_pos_y, data_out.deriv_pos_z};
			got.mom  = {data_out.deriv_mom_x, data_out.deriv_mom_y, data_out.deriv_mom_z};
			got.zero = data_out.zero_magnitude;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: pos %h mom %h zero %b",
						got.pos, got.mom, got.zero);
			end else begin
				want = expected_q.pop_front();
				if (got.pos !== want.pos || got.mom !== want.mom || got.zero !== want.zero) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp pos %h mom %h zero %b / got pos %h mom %h zero %b",
							want.pos, want.mom, want.zero, got.pos, got.mom, got.zero);
				end
			end
		end
	end

	// timeout
	initial begin
		#(PERIOD * 2000000);
		$display("tb_lorentz_motion_derivative_unit: FAIL");
		$finish;
	end

	// main sequence
	initial begin
		data_in.valid      = 1'b0;
		data_in.momentum_x = '0;
		data_in.momentum_y = '0;
		data_in.momentum_z = '0;
		data_in.field_x    = '0;
		data_in.field_y    = '0;
		data_in.field_z    = '0;
		data_out.ready     = 1'b0;
		cfg.valid          = 1'b0;
		cfg.index          = '0;
		cfg.data           = '0;
		mode_q     = 1'b0;
		rev_q      = 1'b0;
		coef_q     = lmd_pkg::COEF_RESET;
		mismatches = 0;
		idle_en    = 1'b1;
		hold_seq   = 0;
		hold_seen  = 0;
		hold_left  = 0;
		stall_left = 0;
		arst_n     = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_settings();
		test_backpressure();
		test_full_rate();

		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("tb_lorentz_motion_derivative_unit: PASS");
		end else begin
			$display("tb_lorentz_motion_derivative_unit: FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/lmd_pkg.sv
rtl/lmd_if.sv
rtl/lmd_front.sv
rtl/lmd_isqrt.sv
rtl/lmd_divide.sv
rtl/lorentz_motion_derivative_unit.sv
tb/tb_lorentz_motion_derivative_unit.sv
